// ----- rtl/core/i2cee_pkg.sv -----
`timescale 1ns / 1ps

package i2cee_pkg;

   // operation codes of a request transaction
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_DEVICE_ADDRESS    = 2'd0;
   localparam logic [1:0] REG_ACK_TIMEOUT       = 2'd1;
   localparam logic [1:0] REG_PHASE_TICKS       = 2'd2;
   localparam logic [1:0] REG_WRITE_CYCLE_TICKS = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // reset values of the configuration registers
   localparam logic [6:0]  DEVICE_ADDRESS_RESET    = 7'd80;
   localparam logic [7:0]  ACK_TIMEOUT_RESET       = 8'd100;
   localparam logic [15:0] PHASE_TICKS_RESET       = 16'd1;
   localparam logic [15:0] WRITE_CYCLE_TICKS_RESET = 16'd1100;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [7:0]  ack_timeout;
      logic [15:0] phase_ticks;
      logic [15:0] write_cycle_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] mem_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_payload_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_error;
   } rsp_payload_type;

endpackage

// ----- rtl/core/i2cee_if.sv -----
`timescale 1ns / 1ps

interface i2cee_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] mem_address;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, output operation, output mem_address,
                   output write_data, output sda_in, input ready);
   modport sink (input valid, input operation, input mem_address,
                 input write_data, input sda_in, output ready);
endinterface

interface i2cee_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_pull_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_byte;
   logic       ack_error;

   modport source (output valid, output scl_level, output sda_pull_low,
                   output busy_res, output done_res, output read_byte,
                   output ack_error, input ready);
   modport sink (input valid, input scl_level, input sda_pull_low,
                 input busy_res, input done_res, input read_byte,
                 input ack_error, output ready);
endinterface

// ----- rtl/core/i2cee_seq.sv -----
`timescale 1ns / 1ps

module i2cee_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  i2cee_pkg::req_payload_type req,
   input  i2cee_pkg::cfg_type         cfg,
   output i2cee_pkg::rsp_payload_type result
);

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_RESTART = 4'd1,
      PH_START_A = 4'd2,
      PH_START_B = 4'd3,
      PH_WBIT_LO = 4'd4,
      PH_WBIT_HI = 4'd5,
      PH_ACK_LO  = 4'd6,
      PH_ACK_HI  = 4'd7,
      PH_RBIT_LO = 4'd8,
      PH_RBIT_HI = 4'd9,
      PH_NACK_LO = 4'd10,
      PH_NACK_HI = 4'd11,
      PH_STOP_A  = 4'd12,
      PH_STOP_B  = 4'd13,
      PH_STOP_C  = 4'd14,
      PH_WAIT    = 4'd15
   } phase_type;

   // which byte of the transfer the current ack slot closes
   localparam logic [1:0] STAGE_DEV  = 2'd0;
   localparam logic [1:0] STAGE_ADDR = 2'd1;
   localparam logic [1:0] STAGE_DATA = 2'd2;
   localparam logic [1:0] STAGE_RX   = 2'd3;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [3:0]  bit_count_ff, bit_count_in, cur_bit_count, bit_inc;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [7:0]  poll_count_ff, poll_count_in, cur_poll_count;
   logic [15:0] tick_count_ff, tick_count_in, cur_tick_count;
   logic [7:0]  held_address_ff, held_address_in;
   logic [7:0]  held_data_ff, held_data_in;
   logic        is_read_ff, is_read_in;
   logic [1:0]  stage_ff, stage_in, cur_stage;
   logic [7:0]  rx_value_ff, rx_value_in;
   logic        err_flag_ff, err_flag_in, cur_err_flag;

   logic [15:0] seg_len;
   logic [16:0] tick_inc;
   logic        seg_over;
   logic        wait_over;
   logic        scl;
   logic        pull;
   logic        done;
   logic        start;

   assign start = (phase_ff == PH_IDLE) &&
                  ((req.operation == i2cee_pkg::OP_WRITE) ||
                   (req.operation == i2cee_pkg::OP_READ));

   always_comb begin
      cur_phase      = phase_ff;
      cur_bit_count  = bit_count_ff;
      cur_poll_count = poll_count_ff;
      cur_tick_count = tick_count_ff;
      cur_stage      = stage_ff;
      cur_err_flag   = err_flag_ff;
      held_address_in = held_address_ff;
      held_data_in    = held_data_ff;
      is_read_in      = is_read_ff;
      if (start) begin
         held_address_in = req.mem_address;
         held_data_in    = req.write_data;
         is_read_in      = (req.operation == i2cee_pkg::OP_READ);
         cur_stage       = STAGE_DEV;
         cur_bit_count   = '0;
         cur_poll_count  = '0;
         cur_err_flag    = 1'b0;
         cur_tick_count  = '0;
         cur_phase       = PH_START_A;
      end
   end

   assign seg_len   = (cfg.phase_ticks == '0) ? 16'd1 : cfg.phase_ticks;
   assign tick_inc  = {1'b0, cur_tick_count} + 17'd1;
   assign seg_over  = tick_inc >= {1'b0, seg_len};
   assign wait_over = tick_inc >= {1'b0, cfg.write_cycle_ticks};
   assign bit_inc   = cur_bit_count + 4'd1;

   // bus levels for this tick
   always_comb begin
      case (cur_phase)
         PH_RESTART, PH_ACK_LO, PH_RBIT_LO, PH_NACK_LO: begin
            scl = 1'b0; pull = 1'b0;
         end
         PH_START_B, PH_STOP_B: begin
            scl = 1'b1; pull = 1'b1;
         end
         PH_WBIT_LO: begin
            scl = 1'b0; pull = ~shift_byte_ff[7];
         end
         PH_WBIT_HI: begin
            scl = 1'b1; pull = ~shift_byte_ff[7];
         end
         PH_STOP_A: begin
            scl = 1'b0; pull = 1'b1;
         end
         default: begin
            scl = 1'b1; pull = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in      = cur_phase;
      bit_count_in  = cur_bit_count;
      shift_byte_in = shift_byte_ff;
      poll_count_in = cur_poll_count;
      tick_count_in = cur_tick_count;
      stage_in      = cur_stage;
      rx_value_in   = rx_value_ff;
      err_flag_in   = cur_err_flag;
      done          = 1'b0;
      if (cur_phase != PH_IDLE && cur_phase != PH_WAIT) begin
         tick_count_in = seg_over ? 16'd0 : tick_inc[15:0];
      end
      case (cur_phase)
         PH_RESTART: if (seg_over) phase_in = PH_START_A;
         PH_START_A: if (seg_over) phase_in = PH_START_B;
         PH_START_B: begin
            if (seg_over) begin
               shift_byte_in = {cfg.device_address, cur_stage != STAGE_DEV};
               bit_count_in  = '0;
               phase_in      = PH_WBIT_LO;
            end
         end
         PH_WBIT_LO: if (seg_over) phase_in = PH_WBIT_HI;
         PH_WBIT_HI: begin
            if (seg_over) begin
               shift_byte_in = {shift_byte_ff[6:0], 1'b0};
               bit_count_in  = bit_inc;
               phase_in      = (bit_inc >= 4'd8) ? PH_ACK_LO : PH_WBIT_LO;
            end
         end
         PH_ACK_LO: begin
            if (seg_over) begin
               poll_count_in = '0;
               phase_in      = PH_ACK_HI;
            end
         end
         PH_ACK_HI: begin
            if (seg_over) begin
               if (!req.sda_in) begin
                  case (cur_stage)
                     STAGE_DEV: begin
                        stage_in      = STAGE_ADDR;
                        shift_byte_in = held_address_in;
                        bit_count_in  = '0;
                        phase_in      = PH_WBIT_LO;
                     end
                     STAGE_ADDR: begin
                        stage_in = STAGE_DATA;
                        if (is_read_in) begin
                           phase_in = PH_RESTART;
                        end else begin
                           shift_byte_in = held_data_in;
                           bit_count_in  = '0;
                           phase_in      = PH_WBIT_LO;
                        end
                     end
                     default: begin
                        if (is_read_in) begin
                           stage_in      = STAGE_RX;
                           shift_byte_in = '0;
                           bit_count_in  = '0;
                           phase_in      = PH_RBIT_LO;
                        end else begin
                           phase_in = PH_STOP_A;
                        end
                     end
                  endcase
               end else if (cur_poll_count >= cfg.ack_timeout) begin
                  err_flag_in = 1'b1;
                  phase_in    = PH_STOP_A;
               end else begin
                  // keep clock high and poll again on the next tick
                  poll_count_in = cur_poll_count + 8'd1;
                  tick_count_in = seg_len - 16'd1;
               end
            end
         end
         PH_RBIT_LO: if (seg_over) phase_in = PH_RBIT_HI;
         PH_RBIT_HI: begin
            if (seg_over) begin
               shift_byte_in = {shift_byte_ff[6:0], req.sda_in};
               bit_count_in  = bit_inc;
               phase_in      = (bit_inc >= 4'd8) ? PH_NACK_LO : PH_RBIT_LO;
            end
         end
         PH_NACK_LO: if (seg_over) phase_in = PH_NACK_HI;
         PH_NACK_HI: begin
            if (seg_over) begin
               rx_value_in = shift_byte_ff;
               phase_in    = PH_STOP_A;
            end
         end
         PH_STOP_A: if (seg_over) phase_in = PH_STOP_B;
         PH_STOP_B: if (seg_over) phase_in = PH_STOP_C;
         PH_STOP_C: begin
            if (seg_over) begin
               done = 1'b1;
               if (!is_read_in && !cur_err_flag && cfg.write_cycle_ticks != '0) begin
                  phase_in = PH_WAIT;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_WAIT: begin
            if (wait_over) begin
               phase_in      = PH_IDLE;
               tick_count_in = '0;
            end else begin
               tick_count_in = tick_inc[15:0];
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bit_count_ff    <= '0;
         shift_byte_ff   <= '0;
         poll_count_ff   <= '0;
         tick_count_ff   <= '0;
         held_address_ff <= '0;
         held_data_ff    <= '0;
         is_read_ff      <= 1'b0;
         stage_ff        <= STAGE_DEV;
         rx_value_ff     <= '0;
         err_flag_ff     <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         bit_count_ff    <= bit_count_in;
         shift_byte_ff   <= shift_byte_in;
         poll_count_ff   <= poll_count_in;
         tick_count_ff   <= tick_count_in;
         held_address_ff <= held_address_in;
         held_data_ff    <= held_data_in;
         is_read_ff      <= is_read_in;
         stage_ff        <= stage_in;
         rx_value_ff     <= rx_value_in;
         err_flag_ff     <= err_flag_in;
      end
   end

   assign result.scl_level    = scl;
   assign result.sda_pull_low = pull;
   assign result.busy_res     = (cur_phase != PH_IDLE);
   assign result.done_res     = done;
   assign result.read_byte    = rx_value_in;
   assign result.ack_error    = err_flag_in;

endmodule

// ----- rtl/core/i2c_eeprom_byte_access_master_core.sv -----
`timescale 1ns / 1ps

// Bit-level I2C master for a 2-kbit serial EEPROM doing a byte write or a
// random byte read. Every request transaction is one bus tick; operation
// starts a write or a read when the master is idle and is ignored otherwise.
// One response transaction comes back per request, in the cycle after it is
// accepted, from the output register; a new tick is accepted every cycle as
// long as the response side keeps taking results. Each tick is one pass
// through the phase sequencer between its state registers and the output
// register. A missing acknowledge after ack_timeout polls sets ack_error and
// ends the transfer with a stop and no write-cycle wait. Configuration
// writes take effect on the next tick.
module i2c_eeprom_byte_access_master_core (
   input  logic                                clock,
   input  logic                                reset,
   i2cee_req_if.sink                           req_chan,
   i2cee_rsp_if.source                         rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [i2cee_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [i2cee_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   i2cee_pkg::cfg_type         cfg_ff;
   i2cee_pkg::req_payload_type req;
   i2cee_pkg::rsp_payload_type result;
   i2cee_pkg::rsp_payload_type rsp_ff;
   logic                       rsp_valid_ff;
   logic                       accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign req.operation   = req_chan.operation;
   assign req.mem_address = req_chan.mem_address;
   assign req.write_data  = req_chan.write_data;
   assign req.sda_in      = req_chan.sda_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address    <= i2cee_pkg::DEVICE_ADDRESS_RESET;
         cfg_ff.ack_timeout       <= i2cee_pkg::ACK_TIMEOUT_RESET;
         cfg_ff.phase_ticks       <= i2cee_pkg::PHASE_TICKS_RESET;
         cfg_ff.write_cycle_ticks <= i2cee_pkg::WRITE_CYCLE_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            i2cee_pkg::REG_DEVICE_ADDRESS:
               cfg_ff.device_address <= csr_write_data[6:0];
            i2cee_pkg::REG_ACK_TIMEOUT:
               cfg_ff.ack_timeout <= csr_write_data[7:0];
            i2cee_pkg::REG_PHASE_TICKS:
               cfg_ff.phase_ticks <= csr_write_data;
            i2cee_pkg::REG_WRITE_CYCLE_TICKS:
               cfg_ff.write_cycle_ticks <= csr_write_data;
            default: ;
         endcase
      end
   end

   i2cee_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .req    (req),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.scl_level    = rsp_ff.scl_level;
   assign rsp_chan.sda_pull_low = rsp_ff.sda_pull_low;
   assign rsp_chan.busy_res     = rsp_ff.busy_res;
   assign rsp_chan.done_res     = rsp_ff.done_res;
   assign rsp_chan.read_byte    = rsp_ff.read_byte;
   assign rsp_chan.ack_error    = rsp_ff.ack_error;

endmodule
